### rtl/core/lli_pkg.sv
// ----------------------------------------------------------------------------
// lli_pkg
// Types and constants shared by the pwm interpolation table block: request and
// response structs, opcode and status codes, sequencer states, datapath widths.
// ----------------------------------------------------------------------------
package lli_pkg;

    // field widths
    localparam int PWM_W    = 8;
    localparam int RES_W    = 26;
    localparam int IDX_IN_W = 8;

    // divider widths: numerator is off * dpwm + den - 1, quotient never exceeds dpwm
    localparam int QUO_W = PWM_W;
    localparam int NUM_W = RES_W + PWM_W + 1;
    localparam int DSH_W = RES_W + QUO_W - 1;
    localparam int CNT_W = $clog2(QUO_W);

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // status codes
    localparam logic ST_OK        = 1'b0;
    localparam logic ST_BAD_INDEX = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [IDX_IN_W-1:0] entry_index;
        logic [PWM_W-1:0]    entry_pwm;
        logic [RES_W-1:0]    entry_resistance;
        logic [RES_W-1:0]    target_resistance;
    } lli_cmd_t;

    typedef struct packed {
        logic [PWM_W-1:0] pwm_value;
        logic             status;
    } lli_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_MUL,
        S_ADJ,
        S_DIV
    } lli_state_t;

endpackage

### rtl/core/lut_linear_interpolator.sv
// ----------------------------------------------------------------------------
// lut_linear_interpolator
// Table of (pwm, resistance) pairs with a write port and a piecewise linear
// lookup of pwm for a target resistance, run by a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//   cmd carries one request (valid/stall); rsp returns exactly one response
//   per request, in order. A write stores one entry and answers status 1 when
//   the index is at or beyond TABLE_ENTRIES (table unchanged), else 0.
//   A query answers the clamped or interpolated pwm with status 0.
// Timing
//   A write's response is registered and appears in the cycle after it is taken.
//   A query runs the end-point checks, scans one segment at a time (up to
//   TABLE_ENTRIES-1 segments), then does the multiply and rounding fix-up
//   and the shift-subtract divide before it answers. The table memory port
//   reads one entry per cycle, which sets the scan length.
//   cmd_stall is high while a query is in progress, and while a finished
//   response waits under rsp_stall; a response is held stable until taken.
// Reset
//   Every entry reads as zero after reset through per-entry valid flags, so
//   no clearing pass is needed; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module lut_linear_interpolator
    import lli_pkg::*;
#(
    parameter int TABLE_ENTRIES = 28
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  lli_cmd_t cmd,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output lli_rsp_t rsp
);

    localparam int              IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

    // table storage
    logic [PWM_W-1:0]         mem_pwm [TABLE_ENTRIES];
    logic [RES_W-1:0]         mem_res [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] vld_reg;

    lli_state_t state_reg, state_next;

    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [PWM_W-1:0] rd_pwm_reg;
    logic [RES_W-1:0] rd_res_reg;
    logic             rd_vld_reg;
    logic [PWM_W-1:0] cur_pwm;
    logic [RES_W-1:0] cur_res;

    logic [RES_W-1:0] target_reg, target_next;
    logic [PWM_W-1:0] prev_pwm_reg, prev_pwm_next;
    logic [RES_W-1:0] prev_res_reg, prev_res_next;
    logic [PWM_W-1:0] base_reg, base_next;
    logic [PWM_W-1:0] dp_reg, dp_next;
    logic             fall_reg, fall_next;
    logic [RES_W-1:0] off_reg, off_next;
    logic [RES_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [DSH_W-1:0] den_sh_reg, den_sh_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    lli_rsp_t rsp_reg, rsp_next;
    logic     rsp_valid_reg, rsp_valid_next;

    logic             cmd_take;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             idx_ok;
    logic             in_seg;
    logic             ge;
    logic [NUM_W-1:0] diff;
    logic [QUO_W-1:0] quo_final;
    logic [NUM_W-2:0] prod;

    // handshake
    assign cmd_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // write decode
    assign idx_ok = cmd.entry_index < IDX_IN_W'(TABLE_ENTRIES);
    assign wr_idx = cmd.entry_index[IDX_W-1:0];
    assign wr_en  = cmd_take && (cmd.opcode == OP_WRITE) && idx_ok;

    // entry read back, unwritten entries read as zero
    assign cur_pwm = rd_vld_reg ? rd_pwm_reg : '0;
    assign cur_res = rd_vld_reg ? rd_res_reg : '0;

    // segment test
    assign in_seg = (target_reg >= prev_res_reg) && (target_reg <= cur_res);

    // multiplier and divider step
    assign prod      = {{PWM_W{1'b0}}, off_reg} * {{RES_W{1'b0}}, dp_reg};
    assign ge        = rem_reg >= {{(NUM_W-DSH_W){1'b0}}, den_sh_reg};
    assign diff      = rem_reg - {{(NUM_W-DSH_W){1'b0}}, den_sh_reg};
    assign quo_final = {quo_reg[QUO_W-2:0], ge};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take && (cmd.opcode == OP_QUERY))
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                state_next = (target_reg <= cur_res) ? S_IDLE : S_LAST;
            end
            S_LAST:
            begin
                state_next = (target_reg >= cur_res) ? S_IDLE : S_SCAN;
            end
            S_SCAN:
            begin
                if (in_seg)
                begin
                    state_next = (prev_res_reg == cur_res) ? S_IDLE : S_MUL;
                end
                else if (addr_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                state_next = S_ADJ;
            end
            S_ADJ:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and response
    always_comb
    begin
        addr_next      = addr_reg;
        target_next    = target_reg;
        prev_pwm_next  = prev_pwm_reg;
        prev_res_next  = prev_res_reg;
        base_next      = base_reg;
        dp_next        = dp_reg;
        fall_next      = fall_reg;
        off_next       = off_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        den_sh_next    = den_sh_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    if (cmd.opcode == OP_WRITE)
                    begin
                        rsp_next.pwm_value = '0;
                        rsp_next.status    = idx_ok ? ST_OK : ST_BAD_INDEX;
                        rsp_valid_next     = 1'b1;
                    end
                    else
                    begin
                        target_next = cmd.target_resistance;
                        addr_next   = '0;
                    end
                end
            end
            S_FIRST:
            begin
                // clamp below the first entry
                if (target_reg <= cur_res)
                begin
                    rsp_next.pwm_value = cur_pwm;
                    rsp_next.status    = ST_OK;
                    rsp_valid_next     = 1'b1;
                end
                else
                begin
                    prev_pwm_next = cur_pwm;
                    prev_res_next = cur_res;
                    addr_next     = LAST;
                end
            end
            S_LAST:
            begin
                // clamp above the last entry
                if (target_reg >= cur_res)
                begin
                    rsp_next.pwm_value = cur_pwm;
                    rsp_next.status    = ST_OK;
                    rsp_valid_next     = 1'b1;
                end
                else
                begin
                    addr_next = IDX_W'(1);
                end
            end
            S_SCAN:
            begin
                if (in_seg)
                begin
                    if (prev_res_reg == cur_res)
                    begin
                        rsp_next.pwm_value = prev_pwm_reg;
                        rsp_next.status    = ST_OK;
                        rsp_valid_next     = 1'b1;
                    end
                    else
                    begin
                        base_next = prev_pwm_reg;
                        fall_next = cur_pwm < prev_pwm_reg;
                        dp_next   = (cur_pwm < prev_pwm_reg) ? (prev_pwm_reg - cur_pwm)
                                                             : (cur_pwm - prev_pwm_reg);
                        off_next  = target_reg - prev_res_reg;
                        den_next  = cur_res - prev_res_reg;
                    end
                end
                else if (addr_reg == LAST)
                begin
                    // no segment matched
                    rsp_next.pwm_value = '0;
                    rsp_next.status    = ST_OK;
                    rsp_valid_next     = 1'b1;
                end
                else
                begin
                    prev_pwm_next = cur_pwm;
                    prev_res_next = cur_res;
                    addr_next     = addr_reg + IDX_W'(1);
                end
            end
            S_MUL:
            begin
                rem_next = {1'b0, prod};
            end
            S_ADJ:
            begin
                // falling segment rounds the quotient up
                if (fall_reg)
                begin
                    rem_next = rem_reg + {{(NUM_W-RES_W){1'b0}}, den_reg} - NUM_W'(1);
                end
                den_sh_next = {den_reg, {(QUO_W-1){1'b0}}};
                quo_next    = '0;
                cnt_next    = CNT_W'(QUO_W - 1);
            end
            S_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (ge)
                begin
                    rem_next = diff;
                end
                quo_next    = quo_final;
                den_sh_next = den_sh_reg >> 1;
                cnt_next    = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (fall_reg)
                    begin
                        rsp_next.pwm_value = (quo_final > base_reg) ? '0
                                                                    : (base_reg - quo_final);
                    end
                    else
                    begin
                        rsp_next.pwm_value = base_reg + quo_final;
                    end
                    rsp_next.status = ST_OK;
                    rsp_valid_next  = 1'b1;
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && rsp_stall;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        target_reg   <= target_next;
        prev_pwm_reg <= prev_pwm_next;
        prev_res_reg <= prev_res_next;
        base_reg     <= base_next;
        dp_reg       <= dp_next;
        fall_reg     <= fall_next;
        off_reg      <= off_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        den_sh_reg   <= den_sh_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        rsp_reg      <= rsp_next;
    end

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_pwm[wr_idx] <= cmd.entry_pwm;
            mem_res[wr_idx] <= cmd.entry_resistance;
        end
        rd_pwm_reg <= mem_pwm[addr_next];
        rd_res_reg <= mem_res[addr_next];
        rd_vld_reg <= vld_reg[addr_next];
    end

`ifndef SYNTHESIS
    // no request is taken while a query is in progress
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> cmd_stall)
        else $error("request taken while busy");

    // divider remainder stays below twice the current shifted divisor
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < {1'b0, den_sh_reg, 1'b0})
        else $error("divider quotient overflow");

    // scan never looks at the first entry as the upper end of a segment
    a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> addr_reg != '0)
        else $error("scan address out of order");

    // a query response never reports a write error
    a_query_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) && rsp_valid_next && !(rsp_valid_reg && rsp_stall)
        |=> rsp.status == ST_OK)
        else $error("query response with error status");
`endif

endmodule

### bench/lut_linear_interpolator_tb.sv
// ----------------------------------------------------------------------------
// lut_linear_interpolator_tb
// Self-checking bench for the pwm interpolation table. Requests go in through
// a valid/stall port with random gaps. Each accepted request runs through a
// local table predictor, and the expected response is queued. A response
// monitor compares every response with the oldest queued expectation. The run
// covers directed edge cases, then random sorted tables with queries and
// noise writes, and two long response hold-offs that back up the request side.
// ----------------------------------------------------------------------------
module lut_linear_interpolator_tb;
    import lli_pkg::*;

    localparam int LUT_DEPTH      = 28;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int MAX_PRINTS     = 100;
    localparam logic [RES_W-1:0] RES_MAX = '1;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    lli_cmd_t cmd       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    lli_rsp_t rsp;

    // predicted table contents, cleared like the block at reset
    logic [PWM_W-1:0] pwm_tab [LUT_DEPTH] = '{default: '0};
    logic [RES_W-1:0] res_tab [LUT_DEPTH] = '{default: '0};

    lli_rsp_t    pending_rsp_q [$];
    int unsigned requests_sent  = 0;
    int unsigned responses_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned holds_asked    = 0;
    int unsigned holds_done     = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;

    lut_linear_interpolator #(
        .TABLE_ENTRIES(LUT_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // pwm for a target: clamp at both ends, else first bracketing segment
    function automatic logic [PWM_W-1:0] interp_pwm(input logic [RES_W-1:0] target);
        logic [63:0] den;
        logic [63:0] off;
        logic [63:0] quo;
        if (target <= res_tab[0])
            return pwm_tab[0];
        if (target >= res_tab[LUT_DEPTH-1])
            return pwm_tab[LUT_DEPTH-1];
        for (int i = 0; i < LUT_DEPTH - 1; i++)
        begin
            if (target >= res_tab[i] && target <= res_tab[i+1])
            begin
                if (res_tab[i] == res_tab[i+1])
                    return pwm_tab[i];
                den = 64'(res_tab[i+1]) - 64'(res_tab[i]);
                off = 64'(target) - 64'(res_tab[i]);
                if (pwm_tab[i+1] >= pwm_tab[i])
                begin
                    quo = off * (64'(pwm_tab[i+1]) - 64'(pwm_tab[i])) / den;
                    return pwm_tab[i] + quo[PWM_W-1:0];
                end
                // falling segment: floor of a negative slope rounds away from zero
                quo = (off * (64'(pwm_tab[i]) - 64'(pwm_tab[i+1])) + den - 64'(1)) / den;
                if (quo > 64'(pwm_tab[i]))
                    quo = 64'(pwm_tab[i]);
                return pwm_tab[i] - quo[PWM_W-1:0];
            end
        end
        return '0;
    endfunction

    // apply one request to the predicted table, return its response
    function automatic lli_rsp_t table_response(input lli_cmd_t c);
        lli_rsp_t r;
        r.pwm_value = '0;
        r.status    = ST_OK;
        if (c.opcode == OP_QUERY)
            r.pwm_value = interp_pwm(c.target_resistance);
        else if (c.entry_index < LUT_DEPTH)
        begin
            pwm_tab[c.entry_index] = c.entry_pwm;
            res_tab[c.entry_index] = c.entry_resistance;
        end
        else
            r.status = ST_BAD_INDEX;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request builders, unused fields carry random junk
    // ------------------------------------------------------------------------
    function automatic lli_cmd_t write_cmd(input logic [IDX_IN_W-1:0] idx,
                                           input logic [PWM_W-1:0] pwm,
                                           input logic [RES_W-1:0] res);
        lli_cmd_t c;
        c.opcode            = OP_WRITE;
        c.entry_index       = idx;
        c.entry_pwm         = pwm;
        c.entry_resistance  = res;
        c.target_resistance = RES_W'($urandom);
        return c;
    endfunction

    function automatic lli_cmd_t query_cmd(input logic [RES_W-1:0] target);
        lli_cmd_t c;
        c.opcode            = OP_QUERY;
        c.entry_index       = IDX_IN_W'($urandom);
        c.entry_pwm         = PWM_W'($urandom);
        c.entry_resistance  = RES_W'($urandom);
        c.target_resistance = target;
        return c;
    endfunction

    // target mostly inside the current table span, some at nodes and ends
    function automatic logic [RES_W-1:0] pick_target();
        logic [RES_W-1:0] lo;
        logic [RES_W-1:0] hi;
        lo = res_tab[0];
        hi = res_tab[LUT_DEPTH-1];
        case ($urandom_range(9))
            0: return res_tab[$urandom_range(LUT_DEPTH-1)];
            1: return $urandom_range(1) ? RES_MAX : RES_W'(0);
            2: return RES_W'($urandom);
            3: return (lo != 0) ? lo - 1'b1 : lo;
            4: return (hi != RES_MAX) ? hi + 1'b1 : hi;
            default: return (lo < hi) ? RES_W'($urandom_range(hi, lo)) : RES_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    task automatic send_request(input lli_cmd_t c);
        // random gap before the request
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        pending_rsp_q.push_back(table_response(c));
        requests_sent++;
    endtask

    // ------------------------------------------------------------------------
    // response monitor and receiver stalls
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch on response %0d, %s: expected 0x%0h, got 0x%0h",
                     responses_seen, what, want, got);
        mismatch_count++;
    endtask

    task automatic check_response(input lli_rsp_t got);
        lli_rsp_t want;
        if (pending_rsp_q.size() == 0)
        begin
            report_mismatch("response with no request pending", 32'(0), 32'(got));
            return;
        end
        want = pending_rsp_q.pop_front();
        if (got.pwm_value !== want.pwm_value)
            report_mismatch("pwm_value", 32'(want.pwm_value), 32'(got.pwm_value));
        if (got.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(got.status));
    endtask

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            check_response(rsp);
            responses_seen++;
        end
        // long hold-off when a test asks for one
        if (hold_left == 0 && holds_done != holds_asked)
        begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d responses pending",
                     quiet_cycles, pending_rsp_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // cleared table answers zero at both ends
    task automatic test_reset_contents();
        send_request(query_cmd(RES_W'(0)));
        send_request(query_cmd(RES_MAX));
    endtask

    // writes past the table end are refused and change nothing
    task automatic test_bad_index();
        send_request(write_cmd(IDX_IN_W'(LUT_DEPTH), 8'hFF, RES_MAX));
        send_request(write_cmd(8'hFF, 8'hFF, RES_MAX));
        send_request(write_cmd(8'h80, 8'h55, RES_W'(1)));
    endtask

    // rising and falling segments, nodes, clamps and an unsorted table
    task automatic test_interpolation();
        send_request(write_cmd(8'd0, 8'h00, RES_W'(1000)));
        send_request(write_cmd(8'd1, 8'hFF, RES_W'(2000)));
        send_request(write_cmd(8'd2, 8'h00, RES_W'(3000)));
        send_request(write_cmd(IDX_IN_W'(LUT_DEPTH - 1), 8'hFF, RES_MAX));
        send_request(query_cmd(RES_W'(0)));
        send_request(query_cmd(RES_W'(999)));
        send_request(query_cmd(RES_W'(1000)));
        send_request(query_cmd(RES_W'(1500)));
        send_request(query_cmd(RES_W'(2000)));
        send_request(query_cmd(RES_W'(2500)));
        send_request(query_cmd(RES_W'(3000)));
        send_request(query_cmd(RES_W'(3001)));
        send_request(query_cmd(RES_MAX - 1'b1));
        send_request(query_cmd(RES_MAX));
        // out of order entry: the first bracketing segment wins
        send_request(write_cmd(8'd1, 8'd100, RES_W'(5000)));
        send_request(query_cmd(RES_W'(4000)));
    endtask

    // sorted random table, written in either direction
    task automatic load_sorted_table();
        logic [RES_W-1:0] vals [$];
        int unsigned span;
        int idx;
        bit backwards;
        case ($urandom_range(3))
            0: span = 31;
            1: span = 255;
            2: span = 65535;
            default: span = 32'(RES_MAX);
        endcase
        for (int i = 0; i < LUT_DEPTH; i++)
            vals.push_back(RES_W'($urandom_range(span)));
        vals.sort();
        backwards = 1'($urandom_range(1));
        for (int i = 0; i < LUT_DEPTH; i++)
        begin
            idx = backwards ? LUT_DEPTH - 1 - i : i;
            send_request(write_cmd(IDX_IN_W'(idx), PWM_W'($urandom), vals[idx]));
        end
    endtask

    // tables followed by queries mixed with noise writes
    task automatic test_random_tables(input int unsigned count);
        int unsigned stop_at;
        lli_cmd_t c;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at)
        begin
            load_sorted_table();
            repeat ($urandom_range(40, 15))
            begin
                if ($urandom_range(99) < 12)
                    c = write_cmd(IDX_IN_W'($urandom), PWM_W'($urandom), RES_W'($urandom));
                else
                    c = query_cmd(pick_target());
                send_request(c);
            end
        end
    endtask

    // responses held off while requests keep coming
    task automatic test_backpressure();
        int unsigned saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        holds_asked++;
        repeat (12)
            send_request(query_cmd(pick_target()));
        send_idle_pct = saved_pct;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 60;
        test_reset_contents();
        test_bad_index();
        test_interpolation();
        test_random_tables(500);

        send_idle_pct = 60;
        recv_idle_pct = 37;
        test_random_tables(500);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_tables(500);
        test_backpressure();

        // drain
        cmd_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/lli_pkg.sv
rtl/core/lut_linear_interpolator.sv
bench/lut_linear_interpolator_tb.sv
